// ===== design/jcq_pkg.sv =====
// Package for the JPEG coefficient quantiser: base tables, widths and sequencer states.
package jcq_pkg;

    localparam int BLOCK_SIZE  = 64;
    localparam int POS_W       = 6;
    localparam int STEP_W      = 13;
    localparam int SAMPLE_W    = 16;
    localparam int RESULT_W    = 29;
    localparam int QUALITY_W   = 7;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int ENTRY_W     = RECIP_W + STEP_W;
    localparam int TABLE_DEPTH = 2 * BLOCK_SIZE;
    localparam int ADDR_W      = POS_W + 1;
    localparam int DIV_W       = RECIP_W;
    localparam int DIV_CNT_W   = 5;

    // scale * base + 50 stays below 2^20; divide it by 100 through a reciprocal
    localparam int STEP_NUM_W       = 20;
    localparam int STEP_RECIP_W     = 20;
    localparam int STEP_RECIP_SHIFT = 26;

    localparam logic [QUALITY_W-1:0]    QUALITY_RESET = 7'd50;
    localparam logic [QUALITY_W-1:0]    QUALITY_MIN   = 7'd1;
    localparam logic [QUALITY_W-1:0]    QUALITY_MAX   = 7'd100;
    localparam logic [QUALITY_W-1:0]    QUALITY_KNEE  = 7'd50;
    localparam logic [STEP_W-1:0]       SCALE_NUM     = 13'd5000;
    localparam logic [STEP_W-1:0]       SCALE_TOP     = 13'd200;
    localparam logic [STEP_W-1:0]       STEP_ROUND    = 13'd50;
    // ceil(2^26 / 100), exact for every numerator below 2^20
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP    = 20'd671089;

    localparam logic [6:0] LUMA_BASE [BLOCK_SIZE] = '{
        7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
        7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
        7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
        7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
        7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
        7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
        7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
        7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [6:0] CHROMA_BASE [BLOCK_SIZE] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

    typedef enum logic [2:0] {
        RB_IDLE,
        RB_SCALE_GO,
        RB_SCALE_WAIT,
        RB_STEP_GO,
        RB_STEP_MUL,
        RB_RECIP_GO,
        RB_RECIP_WAIT,
        RB_WRITE
    } rb_state_t;

endpackage

// ===== design/jcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/jpeg_coefficient_quantiser.sv =====
// An accepted input word passes the v1, v2 and v3 registers and the output register.
// Throughput: one word per cycle, except during a rebuild or while a low m_axis_tready holds
// a valid output; the step/reciprocal RAM read port carries every word. Each RAM entry holds
// a step and its reciprocal, so quantise needs one multiply. Reset and every quality write
// rebuild all 128 entries, one serial division per entry, while s_axis_tready stays low.
module jpeg_coefficient_quantiser #(
    parameter int FRAC_BITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,        // quality
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // position[5:0], sample_in[21:6], zero pad
    input  logic [1:0]  s_axis_tuser,    // req_type[0], use_luma[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata     // result_value[28:0], step_used[41:29], zero pad
);

    localparam int NUM_W = 19 + FRAC_BITS;
    localparam int SH    = FRAC_BITS + 1;
    localparam int A_W   = jcq_pkg::SAMPLE_W + 1;
    localparam int B_W   = jcq_pkg::RECIP_W + 1;
    localparam int P_W   = A_W + B_W;
    localparam int M_W   = jcq_pkg::SAMPLE_W;
    localparam int SP_W  = jcq_pkg::STEP_NUM_W + jcq_pkg::STEP_RECIP_W;

    // ---------------- configuration and table rebuild ----------------
    logic [jcq_pkg::QUALITY_W-1:0] quality_reg;
    jcq_pkg::rb_state_t            rb_state_reg, rb_state_next;
    logic [jcq_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [jcq_pkg::STEP_W-1:0]    scale_reg, scale_next;
    logic [jcq_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [jcq_pkg::STEP_NUM_W-1:0] step_num_reg, step_num_next;

    logic [jcq_pkg::DIV_W-1:0]     div_quot_reg;
    logic [jcq_pkg::STEP_W-1:0]    div_rem_reg;
    logic [jcq_pkg::STEP_W-1:0]    div_den_reg;
    logic [jcq_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                          div_busy;
    logic                          div_start;
    logic [jcq_pkg::DIV_W-1:0]     div_dividend;
    logic [jcq_pkg::STEP_W-1:0]    div_divisor;
    logic [jcq_pkg::STEP_W:0]      div_trial;
    logic [jcq_pkg::STEP_W:0]      div_shift;

    logic [6:0]                    base_val;
    logic [jcq_pkg::STEP_NUM_W-1:0] step_num;
    logic [SP_W-1:0]               step_prod;
    logic [jcq_pkg::STEP_W-1:0]    step_quot;
    logic                          ram_we;
    logic [jcq_pkg::ENTRY_W-1:0]   ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_reg <= jcq_pkg::QUALITY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_data < jcq_pkg::QUALITY_MIN)
            begin
                quality_reg <= jcq_pkg::QUALITY_MIN;
            end
            else if (cfg_data > jcq_pkg::QUALITY_MAX)
            begin
                quality_reg <= jcq_pkg::QUALITY_MAX;
            end
            else
            begin
                quality_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_state_reg <= jcq_pkg::RB_SCALE_GO;
            idx_reg      <= '0;
        end
        else
        begin
            rb_state_reg <= rb_state_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg    <= scale_next;
        step_reg     <= step_next;
        step_num_reg <= step_num_next;
    end

    assign base_val = idx_reg[jcq_pkg::POS_W] ? jcq_pkg::LUMA_BASE[idx_reg[jcq_pkg::POS_W-1:0]]
                                              : jcq_pkg::CHROMA_BASE[idx_reg[jcq_pkg::POS_W-1:0]];
    assign step_num  = jcq_pkg::STEP_NUM_W'(scale_reg * base_val)
                     + jcq_pkg::STEP_NUM_W'(jcq_pkg::STEP_ROUND);
    // divide by 100: multiply by the reciprocal and drop the fraction
    assign step_prod = step_num_reg * jcq_pkg::STEP_RECIP;
    assign step_quot = step_prod[jcq_pkg::STEP_RECIP_SHIFT +: jcq_pkg::STEP_W];

    always_comb
    begin
        rb_state_next = rb_state_reg;
        idx_next      = idx_reg;
        scale_next    = scale_reg;
        step_next     = step_reg;
        step_num_next = step_num_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = step_reg;
        ram_we        = 1'b0;
        unique case (rb_state_reg)
            jcq_pkg::RB_IDLE:
            begin
            end
            jcq_pkg::RB_SCALE_GO:
            begin
                if (quality_reg < jcq_pkg::QUALITY_KNEE)
                begin
                    div_start     = 1'b1;
                    div_dividend  = jcq_pkg::DIV_W'(jcq_pkg::SCALE_NUM);
                    div_divisor   = jcq_pkg::STEP_W'(quality_reg);
                    rb_state_next = jcq_pkg::RB_SCALE_WAIT;
                end
                else
                begin
                    scale_next    = jcq_pkg::SCALE_TOP
                                  - jcq_pkg::STEP_W'({quality_reg, 1'b0});
                    rb_state_next = jcq_pkg::RB_STEP_GO;
                end
            end
            jcq_pkg::RB_SCALE_WAIT:
            begin
                if (!div_busy)
                begin
                    scale_next    = div_quot_reg[jcq_pkg::STEP_W-1:0];
                    rb_state_next = jcq_pkg::RB_STEP_GO;
                end
            end
            jcq_pkg::RB_STEP_GO:
            begin
                step_num_next = step_num;
                rb_state_next = jcq_pkg::RB_STEP_MUL;
            end
            jcq_pkg::RB_STEP_MUL:
            begin
                // raise a zero step to one
                step_next = (step_quot == '0) ? jcq_pkg::STEP_W'(1) : step_quot;
                rb_state_next = jcq_pkg::RB_RECIP_GO;
            end
            jcq_pkg::RB_RECIP_GO:
            begin
                // ceil(2^RECIP_SHIFT / step)
                div_start     = 1'b1;
                div_dividend  = (jcq_pkg::DIV_W'(1) << jcq_pkg::RECIP_SHIFT)
                              + jcq_pkg::DIV_W'(step_reg) - jcq_pkg::DIV_W'(1);
                div_divisor   = step_reg;
                rb_state_next = jcq_pkg::RB_RECIP_WAIT;
            end
            jcq_pkg::RB_RECIP_WAIT:
            begin
                if (!div_busy)
                begin
                    rb_state_next = jcq_pkg::RB_WRITE;
                end
            end
            jcq_pkg::RB_WRITE:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == jcq_pkg::ADDR_W'(jcq_pkg::TABLE_DEPTH - 1))
                begin
                    rb_state_next = jcq_pkg::RB_IDLE;
                end
                else
                begin
                    rb_state_next = jcq_pkg::RB_STEP_GO;
                end
            end
            default:
            begin
                rb_state_next = jcq_pkg::RB_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            rb_state_next = jcq_pkg::RB_SCALE_GO;
            idx_next      = '0;
        end
    end

    assign ram_wdata = {div_quot_reg, step_reg};

    // restoring divider, one quotient bit per cycle
    assign div_busy  = (div_cnt_reg != '0);
    assign div_shift = {div_rem_reg, div_quot_reg[jcq_pkg::DIV_W-1]};
    assign div_trial = div_shift - {1'b0, div_den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (div_start)
        begin
            div_cnt_reg <= jcq_pkg::DIV_CNT_W'(jcq_pkg::DIV_W);
        end
        else if (div_busy)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_quot_reg <= div_dividend;
            div_rem_reg  <= '0;
            div_den_reg  <= div_divisor;
        end
        else if (div_busy)
        begin
            if (!div_trial[jcq_pkg::STEP_W])
            begin
                div_rem_reg  <= div_trial[jcq_pkg::STEP_W-1:0];
                div_quot_reg <= {div_quot_reg[jcq_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg  <= div_shift[jcq_pkg::STEP_W-1:0];
                div_quot_reg <= {div_quot_reg[jcq_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- coefficient pipeline ----------------
    logic                          pipe_en;
    logic                          in_accept;
    logic [jcq_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [jcq_pkg::ADDR_W-1:0]    ram_raddr;

    logic                          v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                          req1_reg, req2_reg, req3_reg;
    logic signed [jcq_pkg::SAMPLE_W-1:0] x1_reg;
    logic                          neg2_reg, neg3_reg;
    logic signed [A_W-1:0]         a2_reg;
    logic signed [B_W-1:0]         b2_reg;
    logic [jcq_pkg::STEP_W-1:0]    step2_reg, step3_reg;
    logic signed [P_W-1:0]         prod3_reg;
    logic [47:0]                   out_data_reg;

    logic [jcq_pkg::STEP_W-1:0]    q1;
    logic [jcq_pkg::RECIP_W-1:0]   r1;
    logic signed [NUM_W-1:0]       num;
    logic signed [NUM_W-1:0]       num_sh;
    logic signed [A_W:0]           n_ext;
    logic                          neg1;
    logic [A_W:0]                  mag;
    logic signed [A_W-1:0]         a_next;
    logic signed [B_W-1:0]         b_next;
    logic [A_W-1:0]                quot3;
    logic [jcq_pkg::RESULT_W-1:0]  result3;

    assign pipe_en       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en && (rb_state_reg == jcq_pkg::RB_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign ram_raddr     = {s_axis_tuser[1], s_axis_tdata[jcq_pkg::POS_W-1:0]};

    jcq_ram #(
        .WIDTH (jcq_pkg::ENTRY_W),
        .DEPTH (jcq_pkg::TABLE_DEPTH)
    ) u_step_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (pipe_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // quantise: floor((2x+d)/(2d)) = floor(floor((2x+d)/2^(F+1)) / q), by reciprocal
    always_comb
    begin
        q1     = ram_rdata[jcq_pkg::STEP_W-1:0];
        r1     = ram_rdata[jcq_pkg::ENTRY_W-1:jcq_pkg::STEP_W];
        num    = (NUM_W'(x1_reg) <<< 1) + (NUM_W'(q1) << FRAC_BITS);
        num_sh = num >>> SH;
        n_ext  = (A_W + 1)'(num_sh);
        neg1   = n_ext[A_W];
        mag    = neg1 ? ((A_W + 1)'(-n_ext) + (A_W + 1)'(q1) - (A_W + 1)'(1))
                      : (A_W + 1)'(n_ext);
        if (req1_reg)
        begin
            a_next = A_W'(x1_reg);
            b_next = B_W'(q1);
        end
        else
        begin
            a_next = A_W'(mag[M_W-1:0]);
            b_next = B_W'(r1);
        end
    end

    assign quot3   = prod3_reg[jcq_pkg::RECIP_SHIFT +: A_W];
    assign result3 = req3_reg ? prod3_reg[jcq_pkg::RESULT_W-1:0]
                   : (neg3_reg ? -jcq_pkg::RESULT_W'(quot3) : jcq_pkg::RESULT_W'(quot3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg        <= in_accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            req1_reg     <= s_axis_tuser[0];
            x1_reg       <= s_axis_tdata[jcq_pkg::POS_W +: jcq_pkg::SAMPLE_W];
            req2_reg     <= req1_reg;
            neg2_reg     <= neg1;
            a2_reg       <= a_next;
            b2_reg       <= b_next;
            step2_reg    <= q1;
            req3_reg     <= req2_reg;
            neg3_reg     <= neg2_reg;
            prod3_reg    <= P_W'(a2_reg) * P_W'(b2_reg);
            step3_reg    <= step2_reg;
            out_data_reg <= {6'd0, step3_reg, result3};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_no_input_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (rb_state_reg != jcq_pkg::RB_IDLE) |-> !s_axis_tready)
        else $error("input taken while step tables rebuild");

    a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
        (quality_reg >= jcq_pkg::QUALITY_MIN) && (quality_reg <= jcq_pkg::QUALITY_MAX))
        else $error("quality register out of range");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (rb_state_reg == jcq_pkg::RB_SCALE_GO) && (idx_reg == '0))
        else $error("quality write did not restart rebuild");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_wdata[jcq_pkg::STEP_W-1:0] != '0) && !div_busy)
        else $error("zero step or busy divider at table write");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (rb_state_reg == jcq_pkg::RB_RECIP_GO) && !cfg_we |=> div_busy)
        else $error("divider not running after reciprocal start");

endmodule
